### sv/ivc_pkg.sv
`default_nettype none
package ivc_pkg;
    localparam int W = 32;

    typedef enum logic [1:0] {
        MODE_LOG     = 2'd0,
        MODE_SET     = 2'd1,
        MODE_COMBINE = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SQUARE,
        ST_DIV_PART,
        ST_DIV_F,
        ST_SQRT,
        ST_ERR,
        ST_DIV_REL,
        ST_DIV_PER,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_PART,
        DIV_F,
        DIV_REL,
        DIV_PER
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     shift_step;
        logic     square;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     err_update;
        logic     out_load;
    } ctrl_t;

    typedef struct packed {
        logic shift_done;
        logic sum_zero;
        logic merge;
        logic div_done;
        logic sqrt_done;
        logic busy_iter;
    } stat_t;
endpackage
`default_nettype wire

### sv/ivc_in_if.sv
`default_nettype none
interface ivc_in_if;
    import ivc_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic signed [31:0] in_estimate;
    logic [31:0] in_error;
    logic [30:0] in_count;
    modport source (output valid, mode, in_estimate, in_error, in_count, input ready);
    modport sink (input valid, mode, in_estimate, in_error, in_count, output ready);
endinterface
`default_nettype wire

### sv/ivc_out_if.sv
`default_nettype none
interface ivc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] event_total;
    logic signed [31:0] cur_estimate;
    logic [31:0] cur_error;
    logic [31:0] relative_error;
    logic signed [31:0] per_event;
    modport source (output valid, event_total, cur_estimate, cur_error, relative_error,
                    per_event, input ready);
    modport sink (input valid, event_total, cur_estimate, cur_error, relative_error,
                  per_event, output ready);
endinterface
`default_nettype wire

### sv/ivc_ctrl.sv
`default_nettype none
module ivc_ctrl
    import ivc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output logic       in_ready,
    output ctrl_t      ctrl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        ctrl.div_sel = DIV_REL;
        in_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.load = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!stat.merge)
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel = DIV_REL;
                    state_next = ST_DIV_REL;
                end
                else if (stat.shift_done)
                    state_next = ST_SQUARE;
                else
                    ctrl.shift_step = 1'b1;
            end
            ST_SQUARE:
            begin
                ctrl.square = 1'b1;
                state_next = ST_DIV_PART;
            end
            ST_DIV_PART:
            begin
                if (stat.sum_zero)
                begin
                    ctrl.err_update = 1'b1;
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel = DIV_REL;
                    state_next = ST_DIV_REL;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel = DIV_PART;
                    state_next = ST_DIV_F;
                end
            end
            ST_DIV_F:
            begin
                ctrl.div_sel = DIV_PART;
                if (stat.div_done)
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel = DIV_F;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                ctrl.div_sel = DIV_F;
                if (stat.div_done)
                begin
                    ctrl.sqrt_start = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                if (stat.sqrt_done)
                begin
                    ctrl.err_update = 1'b1;
                    state_next = ST_DIV_PER;
                end
            end
            ST_DIV_PER:
            begin
                ctrl.div_start = 1'b1;
                ctrl.div_sel = DIV_REL;
                state_next = ST_DIV_REL;
            end
            ST_DIV_REL:
            begin
                ctrl.div_sel = DIV_REL;
                if (stat.div_done)
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel = DIV_PER;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                ctrl.div_sel = DIV_PER;
                if (!stat.busy_iter && out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> state_reg == ST_SHIFT)
        else $error("load did not start work");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> state_reg == ST_IDLE)
        else $error("result not closing item");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.busy_iter)
        else $error("ready while iterating");
endmodule
`default_nettype wire

### sv/ivc_datapath.sv
`default_nettype none
module ivc_datapath
    import ivc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_t       ctrl,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] in_estimate,
    input  wire logic [31:0] in_error,
    input  wire logic [30:0] in_count,
    output stat_t            stat,
    output logic [31:0]      res_count,
    output logic [31:0]      res_estimate,
    output logic [31:0]      res_error,
    output logic [31:0]      res_rel,
    output logic [31:0]      res_per
);
    logic [31:0] count_reg, estimate_reg, error_reg;
    logic [31:0] x2_reg, e2_reg;
    logic        merge_reg;
    logic [4:0]  s_reg;
    logic [31:0] n1_reg;
    logic [32:0] sum_reg;
    logic [31:0] a_reg, b_reg;
    logic [32:0] mag_reg;
    logic        neg_reg;

    // shared restoring divider: 64-bit dividend, 33-bit divisor
    logic [63:0] dq_reg;
    logic [33:0] rem_reg;
    logic [32:0] dv_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    div_sel_t    dsel_reg;

    // square root, two bits per step
    logic [63:0] sv_reg;
    logic [31:0] sr_reg;
    logic [33:0] srem_reg;
    logic [5:0]  scnt_reg;
    logic        sbusy_reg;

    logic [31:0] rel_reg, per_reg;

    logic [32:0] count_sum;
    logic [31:0] count_sat;
    logic [32:0] diff;
    logic [33:0] rem_sh, rem_sub;
    logic [63:0] div_num;
    logic [32:0] div_den;
    logic [33:0] s_trial, s_cur;
    logic [63:0] errprod;
    logic [63:0] q_full;
    logic [15:0] n1_w, n2_w;
    logic [31:0] a_w, b_w;

    assign count_sum = {1'b0, count_reg} + {2'b0, in_count};
    assign count_sat = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];
    assign diff = {x2_reg[31], x2_reg} - {estimate_reg[31], estimate_reg};
    assign n1_w = 16'(error_reg >> s_reg);
    assign n2_w = 16'(e2_reg >> s_reg);
    assign a_w  = n1_w * n1_w;
    assign b_w  = n2_w * n2_w;

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (ctrl.div_sel)
            DIV_PART: begin div_num = mag_reg * a_reg;  div_den = sum_reg; end
            DIV_F:    begin div_num = {b_reg, 32'b0};   div_den = sum_reg; end
            DIV_REL:  begin div_num = {16'b0, error_reg, 16'b0};
                            div_den = {1'b0, estimate_reg}; end
            DIV_PER:  begin div_num = {32'b0, estimate_reg};
                            div_den = {1'b0, count_reg}; end
            default:  begin div_num = '0; div_den = 33'd1; end
        endcase
    end

    assign rem_sh  = {rem_reg[32:0], dq_reg[63]};
    assign rem_sub = rem_sh - {1'b0, dv_reg};
    // quotient after the step in progress
    assign q_full  = {dq_reg[62:0], ~rem_sub[33]};
    assign s_cur   = {srem_reg[31:0], sv_reg[63:62]};
    assign s_trial = s_cur - {sr_reg, 2'b01};
    assign errprod = n1_reg * sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            estimate_reg <= '0;
            error_reg <= '0;
            merge_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            sbusy_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                merge_reg <= 1'b0;
                s_reg <= '0;
                x2_reg <= in_estimate;
                e2_reg <= in_error;
                case (mode_t'(mode))
                    MODE_LOG:
                        count_reg <= (count_reg == 32'hFFFF_FFFF) ? count_reg
                                                                  : count_reg + 32'd1;
                    MODE_SET:
                    begin
                        estimate_reg <= in_estimate;
                        error_reg <= in_error;
                    end
                    MODE_COMBINE:
                    begin
                        if (!in_estimate[31] && in_estimate != '0)
                        begin
                            if (estimate_reg[31] || estimate_reg == '0)
                            begin
                                estimate_reg <= in_estimate;
                                error_reg <= in_error;
                            end
                            else
                            begin
                                count_reg <= count_sat;
                                merge_reg <= 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        count_reg <= '0;
                        estimate_reg <= '0;
                        error_reg <= '0;
                    end
                endcase
            end
            if (ctrl.shift_step)
                s_reg <= s_reg + 5'd1;
            if (ctrl.square)
            begin
                n1_reg <= {16'b0, n1_w};
                a_reg <= a_w;
                b_reg <= b_w;
                sum_reg <= {1'b0, a_w} + {1'b0, b_w};
                neg_reg <= diff[32];
                mag_reg <= diff[32] ? 33'(-diff) : diff;
            end
            if (ctrl.div_start)
            begin
                dq_reg <= div_num;
                dv_reg <= div_den;
                dsel_reg <= ctrl.div_sel;
                rem_reg <= '0;
                dcnt_reg <= 7'd64;
                dbusy_reg <= 1'b1;
            end
            else if (dbusy_reg)
            begin
                if (!rem_sub[33])
                begin
                    rem_reg <= rem_sub;
                    dq_reg <= {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    dq_reg <= {dq_reg[62:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1)
                    dbusy_reg <= 1'b0;
            end
            if (stat.div_done)
            begin
                case (dsel_reg)
                    DIV_PART: estimate_reg <= neg_reg ? estimate_reg - q_full[31:0]
                                                      : estimate_reg + q_full[31:0];
                    DIV_F:    sv_reg <= q_full;
                    DIV_REL:  rel_reg <= (q_full[63:32] != '0) ? 32'hFFFF_FFFF
                                                              : q_full[31:0];
                    default:  per_reg <= q_full[31:0];
                endcase
            end
            if (ctrl.sqrt_start)
            begin
                sr_reg <= '0;
                srem_reg <= '0;
                scnt_reg <= 6'd32;
                sbusy_reg <= 1'b1;
            end
            else if (sbusy_reg)
            begin
                sv_reg <= {sv_reg[61:0], 2'b00};
                if (!s_trial[33])
                begin
                    srem_reg <= s_trial;
                    sr_reg <= {sr_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg <= s_cur;
                    sr_reg <= {sr_reg[30:0], 1'b0};
                end
                scnt_reg <= scnt_reg - 6'd1;
                if (scnt_reg == 6'd1)
                    sbusy_reg <= 1'b0;
            end
            if (ctrl.err_update)
                error_reg <= stat.sum_zero ? '0 : 32'((errprod >> 16) << s_reg);
        end
    end

    assign stat.shift_done = ((error_reg >> s_reg) < 32'h1_0000)
                          && ((e2_reg >> s_reg) < 32'h1_0000);
    assign stat.sum_zero   = (sum_reg == '0);
    assign stat.merge      = merge_reg;
    assign stat.div_done   = dbusy_reg && dcnt_reg == 7'd1;
    assign stat.sqrt_done  = !sbusy_reg && !ctrl.sqrt_start;
    assign stat.busy_iter  = dbusy_reg || sbusy_reg;

    assign res_count    = count_reg;
    assign res_estimate = estimate_reg;
    assign res_error    = error_reg;
    assign res_rel      = (estimate_reg[31] || estimate_reg == '0) ? '0 : rel_reg;
    assign res_per      = (estimate_reg[31] || count_reg == '0) ? '0 : per_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |=> dbusy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(dbusy_reg && sbusy_reg))
        else $error("divider and root overlap");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_step |-> s_reg < 5'd16)
        else $error("shift runaway");
endmodule
`default_nettype wire

### sv/inverse_variance_combiner_top.sv
// channel   dir  payload
// in_ch     in   mode, in_estimate, in_error, in_count
// out_ch    out  event_total, cur_estimate, cur_error, relative_error, per_event
//
// One item at a time. Log, set, clear, a combine that does not merge and a merge of two
// zero errors take two divider passes; other merges take the bit-serial 64-step divider (four
// passes), the 32-step root and up to 16 normalizing shifts.
// rst_n clears count, estimate and error asynchronously.
// A held output transfer stalls the last step; the next item enters after it leaves.
`default_nettype none
module inverse_variance_combiner_top
    import ivc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    ivc_in_if.sink   in_ch,
    ivc_out_if.source out_ch
);
    ctrl_t ctrl;
    stat_t stat;
    logic  in_ready;
    logic  out_valid_reg;
    logic [31:0] r_cnt, r_est, r_err, r_rel, r_per;
    logic [31:0] o_cnt_reg, o_est_reg, o_err_reg, o_rel_reg, o_per_reg;
    logic out_free;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = in_ready;

    ivc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_ch.valid && in_ready),
        .out_free(out_free), .stat(stat), .in_ready(in_ready), .ctrl(ctrl)
    );

    ivc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .mode(in_ch.mode),
        .in_estimate(in_ch.in_estimate), .in_error(in_ch.in_error),
        .in_count(in_ch.in_count), .stat(stat),
        .res_count(r_cnt), .res_estimate(r_est), .res_error(r_err),
        .res_rel(r_rel), .res_per(r_per)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            o_cnt_reg <= r_cnt;
            o_est_reg <= r_est;
            o_err_reg <= r_err;
            o_rel_reg <= r_rel;
            o_per_reg <= r_per;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.event_total    = o_cnt_reg;
    assign out_ch.cur_estimate   = o_est_reg;
    assign out_ch.cur_error      = o_err_reg;
    assign out_ch.relative_error = o_rel_reg;
    assign out_ch.per_event      = o_per_reg;
endmodule
`default_nettype wire
